// ----- sv/m64a_pkg.sv -----
`timescale 1ns / 1ps
// m64a_pkg: constants, sequencer states and multiplier request/response types
// for the streaming MurmurHash64A core; no dependencies

package m64a_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
  localparam int unsigned MIX_SHIFT = 47;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  typedef enum logic [3:0] {
    MS_IDLE  = 4'b0001,
    MS_LO    = 4'b0010,
    MS_HI_LO = 4'b0100,
    MS_LO_HI = 4'b1000
  } mul_step_t;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LEN  = 7'b0000010,
    ST_K1   = 7'b0000100,
    ST_K2   = 7'b0001000,
    ST_HM   = 7'b0010000,
    ST_AV   = 7'b0100000,
    ST_FIN  = 7'b1000000
  } seq_state_t;

endpackage

// ----- sv/m64a_mul.sv -----
`timescale 1ns / 1ps
// m64a_mul: iterative 64-bit multiply by the mix constant, low 64 bits kept,
// built on one 32x32 multiplier over three steps; depends on m64a_pkg

module m64a_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  m64a_pkg::mul_req_t req_i,
  output m64a_pkg::mul_rsp_t rsp_o
);
  import m64a_pkg::*;

  mul_step_t   step_r, step_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mul_a, mul_b;
  logic [63:0] pp;

  assign pp = mul_a * mul_b;

  always_comb begin
    step_nxt = step_r;
    a_nxt    = a_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    mul_a    = a_r[31:0];
    mul_b    = MIX_MUL_LO;
    unique case (step_r)
      MS_IDLE: begin
        if (req_i.start) begin
          a_nxt    = req_i.operand;
          step_nxt = MS_LO;
        end
      end
      MS_LO: begin
        acc_nxt  = pp;
        step_nxt = MS_HI_LO;
      end
      MS_HI_LO: begin
        mul_a    = a_r[63:32];
        acc_nxt  = {acc_r[63:32] + pp[31:0], acc_r[31:0]};
        step_nxt = MS_LO_HI;
      end
      MS_LO_HI: begin
        mul_b    = MIX_MUL_HI;
        acc_nxt  = {acc_r[63:32] + pp[31:0], acc_r[31:0]};
        done_nxt = 1'b1;
        step_nxt = MS_IDLE;
      end
      default: step_nxt = MS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= MS_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp_o.done    = done_r;
  assign rsp_o.product = acc_r;

endmodule

// ----- sv/murmur64a_hash_core.sv -----
`timescale 1ns / 1ps
// murmur64a_hash_core: streaming MurmurHash64A top level with sequencer and
// hash registers; depends on m64a_pkg and m64a_mul
//
// channel  direction  handshake            payload
// in_      input      in_valid / in_stall   data_word, byte_count, first/last, length
// out_     output     out_valid / out_stall hash_value
// cfg_     input      cfg_wr_en             cfg_wr_data (hash seed)
//
// every multiply runs on one shared unit as three 32x32 steps plus handoff;
// a full word costs 3 multiplies plus the accept in idle, and no new item is
// taken until the sequencer is back in idle
// a first item adds the length multiply; a last item adds the avalanche multiply
// and the load of the output register; an item taken with no message open is dropped
// in_stall is high whenever the sequencer is busy; a held result blocks new
// items only while the next result waits to load
// synchronous active-low reset clears the state, seed, hash, message flag and out_valid

module murmur64a_hash_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first_item,
  input  logic        in_last_item,
  input  logic [30:0] in_total_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash_value,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data
);
  import m64a_pkg::*;

  seq_state_t  state_r, state_nxt;
  logic [63:0] seed_r;
  logic [63:0] h_r, h_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic [63:0] word_r, word_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  logic        in_acc;
  logic [3:0]  in_cnt_sat;
  logic [63:0] p, p_x;
  logic [63:0] dsp_h, dsp_word, tail_mask;
  logic [3:0]  dsp_cnt;
  logic        dsp_last;
  seq_state_t  dsp_state;
  logic [63:0] dsp_op;

  m64a_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (mul_req),
    .rsp_o (mul_rsp)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign in_cnt_sat = in_byte_count[3] ? 4'd8 : in_byte_count;
  assign p          = mul_rsp.product;
  assign p_x        = p ^ (p >> MIX_SHIFT);

  // pick the first operation of a word, from the inputs or after the length step
  always_comb begin
    if (state_r == ST_IDLE) begin
      dsp_h    = h_r;
      dsp_word = in_data_word;
      dsp_cnt  = in_cnt_sat;
      dsp_last = in_last_item;
    end else begin
      dsp_h    = seed_r ^ p;
      dsp_word = word_r;
      dsp_cnt  = cnt_r;
      dsp_last = last_r;
    end
    tail_mask = (64'h1 << {dsp_cnt[2:0], 3'b000}) - 64'h1;
    if (!dsp_last || dsp_cnt[3]) begin
      dsp_state = ST_K1;
      dsp_op    = dsp_word;
    end else if (dsp_cnt == 4'd0) begin
      dsp_state = ST_AV;
      dsp_op    = dsp_h ^ (dsp_h >> MIX_SHIFT);
    end else begin
      dsp_state = ST_HM;
      dsp_op    = dsp_h ^ (dsp_word & tail_mask);
    end
  end

  always_comb begin
    state_nxt       = state_r;
    h_nxt           = h_r;
    in_msg_nxt      = in_msg_r;
    word_nxt        = word_r;
    cnt_nxt         = cnt_r;
    last_nxt        = last_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_hash_nxt    = out_hash_r;
    mul_req.start   = 1'b0;
    mul_req.operand = dsp_op;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          word_nxt = in_data_word;
          cnt_nxt  = in_cnt_sat;
          last_nxt = in_last_item;
          if (in_first_item) begin
            in_msg_nxt      = 1'b1;
            mul_req.start   = 1'b1;
            mul_req.operand = {33'b0, in_total_length};
            state_nxt       = ST_LEN;
          end else if (in_msg_r) begin
            mul_req.start = 1'b1;
            state_nxt     = dsp_state;
          end
        end
      end
      ST_LEN: begin
        if (mul_rsp.done) begin
          h_nxt         = seed_r ^ p;
          mul_req.start = 1'b1;
          state_nxt     = dsp_state;
        end
      end
      ST_K1: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = p_x;
          state_nxt       = ST_K2;
        end
      end
      ST_K2: begin
        if (mul_rsp.done) begin
          mul_req.start   = 1'b1;
          mul_req.operand = h_r ^ p;
          state_nxt       = ST_HM;
        end
      end
      ST_HM: begin
        if (mul_rsp.done) begin
          if (!last_r) begin
            h_nxt     = p;
            state_nxt = ST_IDLE;
          end else begin
            mul_req.start   = 1'b1;
            mul_req.operand = p_x;
            state_nxt       = ST_AV;
          end
        end
      end
      ST_AV: begin
        if (mul_rsp.done) begin
          h_nxt      = p_x;
          in_msg_nxt = 1'b0;
          state_nxt  = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = h_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seed_r      <= 64'h0;
      h_r         <= 64'h0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      in_msg_r    <= in_msg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        seed_r <= cfg_wr_data;
      end
    end
    word_r     <= word_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= last_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

// ----- sv/m64a_checker.sv -----
`timescale 1ns / 1ps
// m64a_checker: port-level assertions for murmur64a_hash_core, attached by bind
// depends on murmur64a_hash_core port names only

module m64a_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_first_item,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_hash_value
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hash_value))
    else $error("result changed or dropped while stalled");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // no result can appear in the cycle after an item is taken
  a_no_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too soon after an item");

  // a first item always starts the sequencer
  a_first_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_first_item |=> in_stall)
    else $error("first item did not start the sequencer");

endmodule

bind murmur64a_hash_core m64a_checker u_m64a_checker (.*);
